@@ rtl/ist_pkg.sv @@
// ---------------------------------------------------------------------------
// ist_pkg
// Operation and status codes of the independent-set table engine.
// ---------------------------------------------------------------------------
package ist_pkg;

   typedef enum logic [2:0] {
      OP_CLEAR     = 3'd0,
      OP_WRITE     = 3'd1,
      OP_FORGET    = 3'd2,
      OP_INTRODUCE = 3'd3,
      OP_READ      = 3'd4
   } op_type;

   localparam logic ST_DONE   = 1'b0;
   localparam logic ST_REJECT = 1'b1;

endpackage

@@ rtl/ist_ram.sv @@
// ---------------------------------------------------------------------------
// ist_ram
// Generic RAM: one write port, two read ports, registered read data.
// ---------------------------------------------------------------------------
module ist_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

@@ rtl/independent_set_table_engine.sv @@
// ---------------------------------------------------------------------------
// independent_set_table_engine
// Subset-weight table of one bag with clear, write, read, forget, introduce.
// ---------------------------------------------------------------------------
// Clear, write, unknown and rejected ops answer straight from idle; read goes
// through S_READ. Forget sweeps 2^(k-1) entries, introduce 2^(k+1) (k = table
// bits before the op), one entry per cycle through the single write port of
// the bank RAMs. One transaction in flight at a time.
// Reset clears the control state, bank select and table size; the bank RAMs
// are undefined until written and get no clearing pass.
// ---------------------------------------------------------------------------
module independent_set_table_engine
   import ist_pkg::*;
#(
   parameter int MAX_BAG_BITS = 10,
   parameter int VALUE_BITS   = 32
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_operation,
   input  logic [3:0]         req_bit_position,
   input  logic [9:0]         req_entry_index,
   input  logic signed [31:0] req_entry_value,
   input  logic [9:0]         req_entry_pointer,
   input  logic [19:0]        req_vertex_weight,
   input  logic [9:0]         req_adjacency_mask,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_read_value,
   output logic [9:0]         rsp_read_pointer,
   output logic [3:0]         rsp_table_bits,
   output logic               rsp_status
);

   // widths
   localparam int AW    = MAX_BAG_BITS;                     // entry index in one bank
   localparam int DEPTH = 2 ** (AW + 1);                    // both banks
   localparam int CTBW  = $clog2(MAX_BAG_BITS + 1);         // table size log2
   localparam int PW    = (CTBW > 4) ? CTBW : 4;            // position compare
   localparam int IXW   = (AW > 10) ? AW : 10;              // index range check
   localparam int WIDE  = ((VALUE_BITS > 32) ? VALUE_BITS : 32) + 1;
   localparam int SW    = VALUE_BITS + 21;                  // value plus weight

   localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
   localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,   // read data on its way from the RAM
      S_RUN,    // sweeping the table, one entry issued per cycle
      S_FLUSH   // last entry being written back
   } state_type;

   state_type            state_ff;
   logic                 active_ff;
   logic [CTBW-1:0]      ctb_ff;
   logic                 intro_ff;
   logic [AW-1:0]        bit_ff;
   logic [19:0]          weight_ff;
   logic [AW-1:0]        adj_ff;
   logic [AW-1:0]        last_ff;
   logic [AW-1:0]        idx_ff;
   // write-back stage
   logic                 v1_ff;
   logic [AW-1:0]        idx1_ff;
   logic [AW-1:0]        jmask1_ff;
   logic                 fwd_hit_ff;
   logic [VALUE_BITS-1:0] fwd_val_ff;
   // response register
   logic                 rsp_valid_ff;
   logic signed [31:0]   rsp_value_ff;
   logic [9:0]           rsp_pointer_ff;
   logic [3:0]           rsp_bits_ff;
   logic                 rsp_status_ff;

   // RAM ports
   logic                  wr_en;
   logic [AW:0]           wr_addr;
   logic [VALUE_BITS-1:0] wr_val;
   logic [9:0]            wr_ptr;
   logic [AW:0]           rd_addr_a;
   logic [AW:0]           val_addr_b;
   logic [AW:0]           ptr_addr_b;
   logic [VALUE_BITS-1:0] val_rd_a;
   logic [VALUE_BITS-1:0] val_rd_b;
   logic [9:0]            ptr_rd_a;
   logic [9:0]            ptr_rd_b;

   // request decode
   logic                  req_accept;
   op_type                op;
   logic [IXW-1:0]        ix_ext;
   logic                  ix_ok;
   logic [PW-1:0]         pos_ext;
   logic [PW-1:0]         ctb_ext;
   logic signed [WIDE-1:0] wval_ext;
   logic [VALUE_BITS-1:0] wval_clamped;

   // sweep stage, entry issue
   logic [AW-1:0]         lowmask0;
   logic [AW-1:0]         lower0;
   logic [AW-1:0]         fsrc_a0;
   logic [AW-1:0]         isrc0;
   logic [AW-1:0]         hmask0;
   logic [AW-1:0]         jmask0;
   logic [AW-1:0]         nb0;

   // sweep stage, write-back
   logic signed [SW-1:0]   sum1;
   logic [VALUE_BITS-1:0]  sat1;
   logic [VALUE_BITS-1:0]  nbv1;
   logic [VALUE_BITS-1:0]  ival1;
   logic                   fpick_a1;
   logic [VALUE_BITS-1:0]  sweep_val;
   logic [9:0]             sweep_ptr;
   logic signed [WIDE-1:0] rd_ext;

   assign req_stall  = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;
   assign op         = op_type'(req_operation);

   assign ix_ext  = IXW'(req_entry_index);
   assign ix_ok   = (ix_ext >> ctb_ff) == '0;
   assign pos_ext = PW'(req_bit_position);
   assign ctb_ext = PW'(ctb_ff);

   // written values are clamped into the stored range
   assign wval_ext = WIDE'(req_entry_value);
   always_comb begin
      if (wval_ext > WIDE'(VAL_MAX)) begin
         wval_clamped = VAL_MAX;
      end else if (wval_ext < WIDE'(VAL_MIN)) begin
         wval_clamped = VAL_MIN;
      end else begin
         wval_clamped = wval_ext[VALUE_BITS-1:0];
      end
   end

   // entry issue: source addresses and the neighbour subset
   assign lowmask0 = bit_ff - AW'(1);
   assign lower0   = idx_ff & lowmask0;
   assign fsrc_a0  = ((idx_ff & ~lowmask0) << 1) | lower0;           // forget, bit clear
   assign isrc0    = ((idx_ff & ~(lowmask0 | bit_ff)) >> 1) | lower0; // introduce source

   always_comb begin
      hmask0 = '0;
      for (int k = 0; k < AW; k++) begin
         if (idx_ff[k]) begin
            hmask0 = AW'(1) << k;
         end
      end
   end

   // lowest set bit below the new bit, else the highest set bit
   assign jmask0 = (lower0 != '0) ? (lower0 & (~lower0 + AW'(1))) : hmask0;
   assign nb0    = idx_ff & ~jmask0;

   // write-back computation
   assign nbv1 = fwd_hit_ff ? fwd_val_ff : val_rd_b;
   assign sum1 = SW'($signed(val_rd_a)) + SW'($signed({1'b0, weight_ff}));
   assign sat1 = (sum1 > SW'(VAL_MAX)) ? VAL_MAX : sum1[VALUE_BITS-1:0];

   always_comb begin
      ival1 = val_rd_a;
      if ((idx1_ff & bit_ff) != '0) begin
         ival1 = (&val_rd_a) ? '1 : sat1;
         if (idx1_ff != bit_ff) begin
            if ((&nbv1) || ((adj_ff & jmask1_ff) != '0)) begin
               ival1 = '1;
            end
         end
      end
   end

   assign fpick_a1  = $signed(val_rd_a) >= $signed(val_rd_b);
   assign sweep_val = intro_ff ? ival1 : (fpick_a1 ? val_rd_a : val_rd_b);
   assign sweep_ptr = (intro_ff || fpick_a1) ? ptr_rd_a : ptr_rd_b;

   assign rd_ext = WIDE'($signed(val_rd_a));

   // RAM port selection
   always_comb begin
      wr_en      = v1_ff;
      wr_addr    = {~active_ff, idx1_ff};
      wr_val     = sweep_val;
      wr_ptr     = sweep_ptr;
      rd_addr_a  = {active_ff, intro_ff ? isrc0 : fsrc_a0};
      val_addr_b = intro_ff ? {~active_ff, nb0} : {active_ff, fsrc_a0 | bit_ff};
      ptr_addr_b = {active_ff, fsrc_a0 | bit_ff};
      if (state_ff == S_IDLE) begin
         rd_addr_a = {active_ff, ix_ext[AW-1:0]};
         if (req_accept && op == OP_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = {active_ff, {AW{1'b0}}};
            wr_val  = '0;
            wr_ptr  = '0;
         end else if (req_accept && op == OP_WRITE && ix_ok) begin
            wr_en   = 1'b1;
            wr_addr = {active_ff, ix_ext[AW-1:0]};
            wr_val  = wval_clamped;
            wr_ptr  = req_entry_pointer;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= 1'b0;
         ctb_ff       <= '0;
         v1_ff        <= 1'b0;
         fwd_hit_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               v1_ff      <= 1'b0;
               fwd_hit_ff <= 1'b0;
               idx_ff     <= '0;
               bit_ff     <= AW'(1) << req_bit_position;
               weight_ff  <= req_vertex_weight;
               adj_ff     <= AW'(req_adjacency_mask);
               if (req_accept) begin
                  rsp_value_ff   <= '0;
                  rsp_pointer_ff <= '0;
                  rsp_bits_ff    <= 4'(ctb_ff);
                  rsp_status_ff  <= ST_DONE;
                  priority case (op)
                     OP_CLEAR: begin
                        ctb_ff       <= '0;
                        rsp_bits_ff  <= '0;
                        rsp_valid_ff <= 1'b1;
                     end
                     OP_WRITE: begin
                        rsp_status_ff <= ix_ok ? ST_DONE : ST_REJECT;
                        rsp_valid_ff  <= 1'b1;
                     end
                     OP_FORGET: begin
                        if (pos_ext >= ctb_ext) begin
                           rsp_status_ff <= ST_REJECT;
                           rsp_valid_ff  <= 1'b1;
                        end else begin
                           intro_ff <= 1'b0;
                           last_ff  <= ~({AW{1'b1}} << (ctb_ff - CTBW'(1)));
                           state_ff <= S_RUN;
                        end
                     end
                     OP_INTRODUCE: begin
                        if (pos_ext > ctb_ext || ctb_ff >= CTBW'(MAX_BAG_BITS)) begin
                           rsp_status_ff <= ST_REJECT;
                           rsp_valid_ff  <= 1'b1;
                        end else begin
                           intro_ff <= 1'b1;
                           last_ff  <= ~({AW{1'b1}} << (ctb_ff + CTBW'(1)));
                           state_ff <= S_RUN;
                        end
                     end
                     OP_READ: begin
                        if (!ix_ok) begin
                           rsp_status_ff <= ST_REJECT;
                           rsp_valid_ff  <= 1'b1;
                        end else begin
                           state_ff <= S_READ;
                        end
                     end
                     default: begin
                        rsp_valid_ff <= 1'b1;
                     end
                  endcase
               end
            end
            S_READ: begin
               rsp_value_ff   <= rd_ext[31:0];
               rsp_pointer_ff <= ptr_rd_a;
               rsp_valid_ff   <= 1'b1;
               state_ff       <= S_IDLE;
            end
            S_RUN: begin
               v1_ff      <= 1'b1;
               idx1_ff    <= idx_ff;
               jmask1_ff  <= jmask0;
               // neighbour being written this cycle: RAM still holds the old word
               fwd_hit_ff <= v1_ff && (nb0 == idx1_ff);
               fwd_val_ff <= sweep_val;
               idx_ff     <= idx_ff + AW'(1);
               if (idx_ff == last_ff) begin
                  state_ff <= S_FLUSH;
               end
            end
            S_FLUSH: begin
               v1_ff        <= 1'b0;
               active_ff    <= ~active_ff;
               ctb_ff       <= intro_ff ? ctb_ff + CTBW'(1) : ctb_ff - CTBW'(1);
               rsp_bits_ff  <= intro_ff ? 4'(ctb_ff + CTBW'(1)) : 4'(ctb_ff - CTBW'(1));
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_value   = rsp_value_ff;
   assign rsp_read_pointer = rsp_pointer_ff;
   assign rsp_table_bits   = rsp_bits_ff;
   assign rsp_status       = rsp_status_ff;

   ist_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (DEPTH)
   ) u_value_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_val),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (val_rd_a),
      .rd_addr_b (val_addr_b),
      .rd_data_b (val_rd_b)
   );

   ist_ram #(
      .WIDTH (10),
      .DEPTH (DEPTH)
   ) u_pointer_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_ptr),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (ptr_rd_a),
      .rd_addr_b (ptr_addr_b),
      .rd_data_b (ptr_rd_b)
   );

endmodule
